[rtl/chsat_pkg.sv]
// Shared constants, types and command/status structs for the separating axis test.
`timescale 1ns / 1ps
`default_nettype none
package chsat_pkg;
  localparam int MaxVertices = 8;
  localparam int MaxNormals = 8;
  localparam int CoordWidth = 32;
  localparam int NormalWidth = 16;
  localparam int VIdxW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int NIdxW = (MaxNormals > 1) ? $clog2(MaxNormals) : 1;
  localparam int VCntW = $clog2(MaxVertices + 1);
  localparam int NCntW = $clog2(MaxNormals + 1);
  localparam int ProdW = CoordWidth + NormalWidth;
  localparam int ProjW = ProdW + 2;

  localparam logic [1:0] KIND_VERT_A = 2'd0;
  localparam logic [1:0] KIND_NORM_A = 2'd1;
  localparam logic [1:0] KIND_VERT_B = 2'd2;
  localparam logic [1:0] KIND_NORM_B = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_AXIS  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_PROJ  = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             load;      // store the accepted item
    logic             clear;     // empty all stores
    logic             axis_hull; // 1: B normal, 0: A normal
    logic [NIdxW-1:0] axis_idx;
    logic             vert_hull;
    logic [VIdxW-1:0] vert_idx;
    logic             init_bounds;
    logic             take_proj;  // projection registered, fold into bounds
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [VCntW-1:0] vcnt_a;
    logic [VCntW-1:0] vcnt_b;
    logic [NCntW-1:0] ncnt_a;
    logic [NCntW-1:0] ncnt_b;
    logic             separated;
    logic             dropped;
  } stat_t;
endpackage
`default_nettype wire

[rtl/chsat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module chsat_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  wire logic [Width-1:0]                      wdata,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic      [Width-1:0]                      rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/chsat_datapath.sv]
// Datapath: hull stores, counts, projection pipeline and interval compare.
`timescale 1ns / 1ps
`default_nettype none
module chsat_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire chsat_pkg::cmd_t      cmd,
  input  wire logic [1:0]           kind,
  input  wire logic [31:0]          x_value,
  input  wire logic [31:0]          y_value,
  input  wire logic [31:0]          z_value,
  output chsat_pkg::stat_t          stat
);
  localparam int CW = chsat_pkg::CoordWidth;
  localparam int NW = chsat_pkg::NormalWidth;
  localparam int PW = chsat_pkg::ProdW;
  localparam int JW = chsat_pkg::ProjW;

  logic [chsat_pkg::VCntW-1:0] vcnt_a, vcnt_b;
  logic [chsat_pkg::NCntW-1:0] ncnt_a, ncnt_b;
  logic dropped;

  logic is_norm, hull_b, full;
  assign is_norm = kind[0];
  assign hull_b = kind[1];
  always_comb begin
    case (kind)
      chsat_pkg::KIND_VERT_A: full = (vcnt_a == chsat_pkg::VCntW'(chsat_pkg::MaxVertices));
      chsat_pkg::KIND_NORM_A: full = (ncnt_a == chsat_pkg::NCntW'(chsat_pkg::MaxNormals));
      chsat_pkg::KIND_VERT_B: full = (vcnt_b == chsat_pkg::VCntW'(chsat_pkg::MaxVertices));
      chsat_pkg::KIND_NORM_B: full = (ncnt_b == chsat_pkg::NCntW'(chsat_pkg::MaxNormals));
      default: full = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      vcnt_a <= '0; vcnt_b <= '0; ncnt_a <= '0; ncnt_b <= '0; dropped <= 1'b0;
    end else if (cmd.load) begin
      if (full) dropped <= 1'b1;
      else begin
        case (kind)
          chsat_pkg::KIND_VERT_A: vcnt_a <= vcnt_a + 1'b1;
          chsat_pkg::KIND_NORM_A: ncnt_a <= ncnt_a + 1'b1;
          chsat_pkg::KIND_VERT_B: vcnt_b <= vcnt_b + 1'b1;
          chsat_pkg::KIND_NORM_B: ncnt_b <= ncnt_b + 1'b1;
          default: ;
        endcase
      end
    end
  end

  logic [3*CW-1:0] vin;
  logic [3*NW-1:0] nin;
  assign vin = {z_value[CW-1:0], y_value[CW-1:0], x_value[CW-1:0]};
  assign nin = {z_value[NW-1:0], y_value[NW-1:0], x_value[NW-1:0]};

  logic wva, wvb, wna, wnb;
  assign wva = cmd.load && !full && !is_norm && !hull_b;
  assign wvb = cmd.load && !full && !is_norm && hull_b;
  assign wna = cmd.load && !full && is_norm && !hull_b;
  assign wnb = cmd.load && !full && is_norm && hull_b;

  logic [3*CW-1:0] va_q, vb_q;
  logic [3*NW-1:0] na_q, nb_q;
  chsat_ram #(.Width(3*CW), .Depth(chsat_pkg::MaxVertices)) u_va (
    .clk, .we(wva), .waddr(vcnt_a[chsat_pkg::VIdxW-1:0]), .wdata(vin),
    .raddr(cmd.vert_idx), .rdata(va_q));
  chsat_ram #(.Width(3*CW), .Depth(chsat_pkg::MaxVertices)) u_vb (
    .clk, .we(wvb), .waddr(vcnt_b[chsat_pkg::VIdxW-1:0]), .wdata(vin),
    .raddr(cmd.vert_idx), .rdata(vb_q));
  chsat_ram #(.Width(3*NW), .Depth(chsat_pkg::MaxNormals)) u_na (
    .clk, .we(wna), .waddr(ncnt_a[chsat_pkg::NIdxW-1:0]), .wdata(nin),
    .raddr(cmd.axis_idx), .rdata(na_q));
  chsat_ram #(.Width(3*NW), .Depth(chsat_pkg::MaxNormals)) u_nb (
    .clk, .we(wnb), .waddr(ncnt_b[chsat_pkg::NIdxW-1:0]), .wdata(nin),
    .raddr(cmd.axis_idx), .rdata(nb_q));

  // Axis and vertex hull selects, delayed to line up with read data.
  logic axis_hull_q, vert_hull_q, vert_hull_q2;
  always_ff @(posedge clk) begin
    axis_hull_q <= cmd.axis_hull;
    vert_hull_q <= cmd.vert_hull;
    vert_hull_q2 <= vert_hull_q;
  end
  logic [3*NW-1:0] nsel;
  logic [3*CW-1:0] vsel;
  assign nsel = axis_hull_q ? nb_q : na_q;
  assign vsel = vert_hull_q ? vb_q : va_q;

  // Three products registered, then summed.
  logic signed [PW-1:0] p0, p1, p2;
  always_ff @(posedge clk) begin
    p0 <= PW'($signed(nsel[NW-1:0]) * $signed(vsel[CW-1:0]));
    p1 <= PW'($signed(nsel[2*NW-1:NW]) * $signed(vsel[2*CW-1:CW]));
    p2 <= PW'($signed(nsel[3*NW-1:2*NW]) * $signed(vsel[3*CW-1:2*CW]));
  end
  logic signed [JW-1:0] proj;
  assign proj = JW'(p0) + JW'(p1) + JW'(p2);

  logic signed [JW-1:0] lo_a, hi_a, lo_b, hi_b;
  logic seen_a, seen_b;
  always_ff @(posedge clk) begin
    if (cmd.init_bounds) begin
      seen_a <= 1'b0; seen_b <= 1'b0;
    end else if (cmd.take_proj) begin
      if (vert_hull_q2) begin
        if (!seen_b || proj < lo_b) lo_b <= proj;
        if (!seen_b || proj > hi_b) hi_b <= proj;
        seen_b <= 1'b1;
      end else begin
        if (!seen_a || proj < lo_a) lo_a <= proj;
        if (!seen_a || proj > hi_a) hi_a <= proj;
        seen_a <= 1'b1;
      end
    end
  end

  assign stat.vcnt_a = vcnt_a;
  assign stat.vcnt_b = vcnt_b;
  assign stat.ncnt_a = ncnt_a;
  assign stat.ncnt_b = ncnt_b;
  assign stat.dropped = dropped;
  assign stat.separated = !seen_a || !seen_b || (hi_b < lo_a) || (lo_b > hi_a);
endmodule
`default_nettype wire

[rtl/chsat_ctrl.sv]
// Controller: load handshake, axis and vertex walk, result strobe.
`timescale 1ns / 1ps
`default_nettype none
module chsat_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             last,
  input  wire chsat_pkg::stat_t stat,
  output chsat_pkg::cmd_t       cmd,
  output logic                  busy,
  output logic                  done,
  output logic                  overlap,
  output logic                  overflow
);
  localparam int VIW = chsat_pkg::VIdxW;
  localparam int NIW = chsat_pkg::NIdxW;

  chsat_pkg::state_t state, state_next;
  logic             axis_hull, axis_hull_next;
  logic [NIW:0]     axis_idx, axis_idx_next;
  logic             vert_hull, vert_hull_next;
  logic [VIW:0]     vert_idx, vert_idx_next;
  logic [1:0]       pipe, pipe_next;  // projections in flight
  logic             sep_found, sep_found_next;
  logic             issue_done, issue_done_next;
  logic             accept;

  assign accept = start && !busy;
  assign busy = !(state == chsat_pkg::ST_IDLE);

  logic [chsat_pkg::NCntW-1:0] ncnt;
  logic [chsat_pkg::VCntW-1:0] vcnt;
  assign ncnt = axis_hull ? stat.ncnt_b : stat.ncnt_a;
  assign vcnt = vert_hull ? stat.vcnt_b : stat.vcnt_a;

  always_comb begin
    state_next = state;
    axis_hull_next = axis_hull;
    axis_idx_next = axis_idx;
    vert_hull_next = vert_hull;
    vert_idx_next = vert_idx;
    pipe_next = pipe;
    sep_found_next = sep_found;
    issue_done_next = issue_done;
    cmd = '0;
    cmd.axis_hull = axis_hull;
    cmd.axis_idx = axis_idx[NIW-1:0];
    cmd.vert_hull = vert_hull;
    cmd.vert_idx = vert_idx[VIW-1:0];
    case (state)
      chsat_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (last) begin
            state_next = chsat_pkg::ST_AXIS;
            axis_hull_next = 1'b1;
            axis_idx_next = '0;
            sep_found_next = 1'b0;
          end
        end
      end
      chsat_pkg::ST_AXIS: begin
        // pick next axis, B normals first then A
        if (chsat_pkg::NCntW'(axis_idx) >= ncnt) begin
          if (axis_hull) begin
            axis_hull_next = 1'b0;
            axis_idx_next = '0;
          end else begin
            state_next = chsat_pkg::ST_DONE;
          end
        end else begin
          cmd.init_bounds = 1'b1;
          vert_hull_next = 1'b0;
          vert_idx_next = '0;
          pipe_next = '0;
          issue_done_next = 1'b0;
          state_next = chsat_pkg::ST_PROJ;
        end
      end
      chsat_pkg::ST_PROJ: begin
        // issue one vertex read per cycle while the hull has vertices left
        cmd.take_proj = pipe[1];
        pipe_next[1] = pipe[0];
        pipe_next[0] = 1'b0;
        if (!issue_done) begin
          if (chsat_pkg::VCntW'(vert_idx) >= vcnt) begin
            if (!vert_hull) begin
              vert_hull_next = 1'b1;
              vert_idx_next = '0;
            end else begin
              issue_done_next = 1'b1;
            end
          end else begin
            pipe_next[0] = 1'b1;
            vert_idx_next = vert_idx + 1'b1;
          end
        end else if (pipe == 2'b00) begin
          state_next = chsat_pkg::ST_CHECK;
        end
      end
      chsat_pkg::ST_CHECK: begin
        if (stat.separated) begin
          sep_found_next = 1'b1;
          state_next = chsat_pkg::ST_DONE;
        end else begin
          axis_idx_next = axis_idx + 1'b1;
          state_next = chsat_pkg::ST_AXIS;
        end
      end
      chsat_pkg::ST_DONE: begin
        cmd.clear = 1'b1;
        state_next = chsat_pkg::ST_IDLE;
      end
      default: state_next = chsat_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chsat_pkg::ST_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == chsat_pkg::ST_DONE);
    end
    if (state == chsat_pkg::ST_DONE) begin
      overlap <= !sep_found;
      overflow <= stat.dropped;
    end
    axis_hull <= axis_hull_next;
    axis_idx <= axis_idx_next;
    vert_hull <= vert_hull_next;
    vert_idx <= vert_idx_next;
    pipe <= pipe_next;
    sep_found <= sep_found_next;
    issue_done <= issue_done_next;
  end
endmodule
`default_nettype wire

[rtl/convex_hull_separating_axis_test.sv]
// Top level of the convex hull separating axis test.
// Usage:
//  - Items (vertices and face normals of hulls A and B) enter on start when
//    busy is low; kind selects the store, last marks the final item.
//  - A non-last item is written to its store as it is accepted; busy stays
//    low, so such items can be taken one per cycle.
//  - On the last item the block walks every stored normal of B, then of A.
//    For each axis it reads one vertex per cycle from the vertex RAMs,
//    forms three registered products and folds their sum into per-hull
//    min/max bounds, then compares the intervals.
//  - After the last item is accepted, busy stays high while the axes are
//    tested, and the first separating axis skips the remaining axes;
//    done rises in the same cycle as busy falls.
//  - The result (overlap, overflow) is shown for one cycle with done high;
//    the receiver cannot stall it. Stores are emptied as it is posted.
//  - Synchronous active-high rst empties the stores and clears the dropped
//    flag; RAM contents are not cleared, no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module convex_hull_separating_axis_test (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] x_value,
  input  wire logic [31:0] y_value,
  input  wire logic [31:0] z_value,
  input  wire logic        last,
  output logic             done,
  output logic             overlap,
  output logic             overflow
);
  chsat_pkg::cmd_t  cmd;
  chsat_pkg::stat_t stat;

  chsat_ctrl u_ctrl (
    .clk, .rst, .start, .last, .stat, .cmd, .busy, .done, .overlap, .overflow
  );

  chsat_datapath u_dp (
    .clk, .rst, .cmd, .kind, .x_value, .y_value, .z_value, .stat
  );
endmodule
`default_nettype wire

[rtl/chsat_checker.sv]
// Port-level checker for the separating axis test, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module chsat_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic last,
  input wire logic done
);
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last |=> busy) else $error("busy not raised after last item");
  a_no_busy_plain: assert property (@(posedge clk) disable iff (rst)
    !busy && !(start && last) |=> !busy) else $error("busy raised without last item");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held more than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");
endmodule

bind convex_hull_separating_axis_test chsat_checker u_chk (
  .clk, .rst, .start, .busy, .last, .done
);
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the convex hull separating axis test.
`timescale 1ns / 1ps
`default_nettype none

// Holds the expected test verdicts and compares the block's results against them.
class hull_verdict_board;
  // loaded hull contents, sign-extended to the stored widths
  longint vert_x[2][$], vert_y[2][$], vert_z[2][$];
  longint norm_x[2][$], norm_y[2][$], norm_z[2][$];
  bit dropped;
  bit want_overlap[$];
  bit want_overflow[$];
  int errors;

  function void clear_hulls();
    for (int h = 0; h < 2; h++) begin
      vert_x[h].delete(); vert_y[h].delete(); vert_z[h].delete();
      norm_x[h].delete(); norm_y[h].delete(); norm_z[h].delete();
    end
    dropped = 0;
  endfunction

  function bit axis_splits(longint nx, longint ny, longint nz);
    longint lo[2], hi[2], p;
    if (vert_x[0].size() == 0 || vert_x[1].size() == 0) return 1;
    for (int h = 0; h < 2; h++) begin
      lo[h] = 64'sh7fffffffffffffff;
      hi[h] = 64'sh8000000000000000;
      foreach (vert_x[h][i]) begin
        p = nx * vert_x[h][i] + ny * vert_y[h][i] + nz * vert_z[h][i];
        if (p > hi[h]) hi[h] = p;
        if (p < lo[h]) lo[h] = p;
      end
    end
    return (hi[1] < lo[0]) || (lo[1] > hi[0]);
  endfunction

  // note an accepted input item
  function void note_item(logic [1:0] k, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z, logic lst);
    int h;
    bit ov;
    h = int'(k[1]);
    if (k[0]) begin
      if (norm_x[h].size() < chsat_pkg::MaxNormals) begin
        norm_x[h] = {norm_x[h], longint'($signed(x[15:0]))};
        norm_y[h] = {norm_y[h], longint'($signed(y[15:0]))};
        norm_z[h] = {norm_z[h], longint'($signed(z[15:0]))};
      end else dropped = 1;
    end else begin
      if (vert_x[h].size() < chsat_pkg::MaxVertices) begin
        vert_x[h] = {vert_x[h], longint'($signed(x))};
        vert_y[h] = {vert_y[h], longint'($signed(y))};
        vert_z[h] = {vert_z[h], longint'($signed(z))};
      end else dropped = 1;
    end
    if (!lst) return;
    ov = 1;
    // B normals first, then A
    for (int s = 1; s >= 0 && ov; s--)
      foreach (norm_x[s][i])
        if (ov && axis_splits(norm_x[s][i], norm_y[s][i], norm_z[s][i])) ov = 0;
    want_overlap = {want_overlap, ov};
    want_overflow = {want_overflow, dropped};
    clear_hulls();
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task check_result(logic ovl, logic ovf);
    if (want_overlap.size() == 0) begin
      report($sformatf("unexpected verdict overlap=%0b overflow=%0b", ovl, ovf));
      return;
    end
    if (ovl !== want_overlap[0])
      report($sformatf("overlap got %0b want %0b", ovl, want_overlap[0]));
    if (ovf !== want_overflow[0])
      report($sformatf("overflow got %0b want %0b", ovf, want_overflow[0]));
    void'(want_overlap.pop_front());
    void'(want_overflow.pop_front());
  endtask
endclass

module tb_top;
  localparam int StallLimit = 20000;  // far above the longest test; margin is wide

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [1:0] kind = chsat_pkg::KIND_VERT_A;
  logic [31:0] x_value = '0, y_value = '0, z_value = '0;
  logic last = 0;
  logic busy, done, overlap, overflow;

  hull_verdict_board board = new();
  bit quiet = 0;        // no gaps in the final stretch
  int idle_cycles = 0;  // watchdog: cycles with no item accepted and no result
  int items_sent = 0;   // input items accepted so far

  always #4 clk = ~clk;

  convex_hull_separating_axis_test uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .x_value(x_value), .y_value(y_value), .z_value(z_value), .last(last),
    .done(done), .overlap(overlap), .overflow(overflow)
  );

  // results cannot be held off: sample every edge where done is high
  always @(posedge clk) begin
    if (!rst && done) board.check_result(overlap, overflow);
  end

  // watchdog on acceptance of either side
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("convex_hull_separating_axis_test test failed");
      $finish;
    end
  end

  // drive one item and hold it until accepted
  task automatic send_item(logic [1:0] k, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic lst);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    kind <= k; x_value <= x; y_value <= y; z_value <= z; last <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(k, x, y, z, lst);
    items_sent++;
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (board.want_overlap.size() != 0) @(posedge clk);
  endtask

  // random coordinate: mostly moderate, sometimes full range
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
    endcase
  endfunction

  // random normal component, upper bits sometimes garbage
  function automatic logic [31:0] rand_norm();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {16'($urandom_range(0, 65535)), 16'h7fff};
      2: return 32'h00008000;
      default: return 32'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // one hull pair load: random counts, random order, last on final item
  task automatic send_load(int budget);
    int cnt[4];
    int total, k;
    total = 0;
    for (int i = 0; i < 4; i++) begin
      cnt[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10)
                                            : $urandom_range(1, budget);
      total += cnt[i];
    end
    if (total == 0) begin cnt[0] = 1; total = 1; end
    while (total > 0) begin
      do k = $urandom_range(0, 3); while (cnt[k] == 0);
      cnt[k]--; total--;
      send_item(2'(k), k[0] ? rand_norm() : rand_coord(),
                k[0] ? rand_norm() : rand_coord(),
                k[0] ? rand_norm() : rand_coord(), total == 0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: hulls apart along x, touching, extremes, empty vertex sets, no normals, full normal store
    send_item(chsat_pkg::KIND_VERT_A, 32'd0, 32'd0, 32'd0, 1'b0);
    send_item(chsat_pkg::KIND_VERT_A, 32'h10000, 32'd0, 32'd0, 1'b0);
    send_item(chsat_pkg::KIND_VERT_B, 32'h30000, 32'd0, 32'd0, 1'b0);
    send_item(chsat_pkg::KIND_NORM_A, 32'h4000, 32'd0, 32'd0, 1'b0);
    send_item(chsat_pkg::KIND_NORM_B, 32'd0, 32'h4000, 32'd0, 1'b1);  // separated on A's normal
    send_item(chsat_pkg::KIND_VERT_A, 32'd0, 32'd0, 32'd0, 1'b0);
    send_item(chsat_pkg::KIND_VERT_B, 32'h10000, 32'd0, 32'd0, 1'b0);
    send_item(chsat_pkg::KIND_VERT_A, 32'h10000, 32'd0, 32'd0, 1'b0);
    send_item(chsat_pkg::KIND_NORM_B, 32'hffff4000, 32'd0, 32'd0, 1'b1);  // touching, wide bits
    send_item(chsat_pkg::KIND_VERT_A, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0);
    send_item(chsat_pkg::KIND_VERT_B, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
    send_item(chsat_pkg::KIND_NORM_A, 32'h8000, 32'h7fff, 32'h8000, 1'b1);
    send_item(chsat_pkg::KIND_NORM_B, 32'h4000, 32'd0, 32'd0, 1'b1);  // empty vertex sets
    send_item(chsat_pkg::KIND_VERT_A, 32'd0, 32'd0, 32'd0, 1'b1);     // no normals
    for (int i = 0; i < 9; i++)
      send_item(chsat_pkg::KIND_NORM_A, 32'h4000, 32'd0, 32'd0, 1'b0);
    send_item(chsat_pkg::KIND_VERT_B, 32'd0, 32'd0, 32'd0, 1'b1);     // full normal store
    drain();  // sender waits until all verdicts are in

    while (items_sent < 1100) begin
      if (items_sent > 950) quiet = 1;
      send_load(($urandom_range(0, 7) == 0) ? 10 : 4);
      if ($urandom_range(0, 20) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk);

    if (board.errors == 0 && board.want_overlap.size() == 0)
      $display("convex_hull_separating_axis_test test passed");
    else
      $display("convex_hull_separating_axis_test test failed");
    $finish;
  end
endmodule
`default_nettype wire
